### hw/rtl/wgm_pkg.sv
// shared types and constants for the wildcard glob matcher
package wgm_pkg;

  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TEXT  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_item_t;

  // broadcast to every cell for the transfer being processed
  typedef struct packed {
    logic            take;
    kind_e           kind;
    logic [7:0]      symbol;
    logic            last;
    logic            room;
    logic [LenW-1:0] load_pos;
    logic [LenW-1:0] len_next;
  } cell_ctrl_t;

  // handed from one column to the next
  typedef struct packed {
    logic old;
    logic adv;
    logic emp;
  } chain_t;

endpackage

### hw/rtl/wgm_cell.sv
// one pattern column: stored byte, match bit and its recurrence
module wgm_cell import wgm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [LenW-1:0] idx_i,
  input  cell_ctrl_t      ctrl_i,
  input  chain_t          left_i,
  output chain_t          right_o
);

  logic [7:0] byte_q;
  logic       bit_q;
  logic       bit_d;
  logic       wr_en;
  logic [7:0] eff_byte;
  logic       active;
  logic       star;
  logic       hit;
  logic       adv;
  logic       emp;

  // pattern byte write for this column
  assign wr_en    = ctrl_i.take && (ctrl_i.kind == KIND_LOAD) && ctrl_i.room
                    && (ctrl_i.load_pos == idx_i);
  assign eff_byte = wr_en ? ctrl_i.symbol : byte_q;
  assign active   = idx_i < ctrl_i.len_next;

  // column recurrence, ripples through stars like a carry
  assign star = (eff_byte == STAR_BYTE);
  assign hit  = (eff_byte == ANY_BYTE) || (eff_byte == ctrl_i.symbol);
  assign adv  = active && (star ? (bit_q || left_i.adv) : (hit && left_i.old));
  assign emp  = active && star && left_i.emp;

  assign right_o = '{old: bit_q, adv: adv, emp: emp};

  // next match bit
  always_comb begin
    bit_d = bit_q;
    if (ctrl_i.take) begin
      unique case (ctrl_i.kind)
        KIND_LOAD:  bit_d = emp;
        KIND_TEXT:  bit_d = ctrl_i.last ? emp : adv;
        KIND_CLEAR: bit_d = 1'b0;
        default:    bit_d = bit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  // pattern store, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      byte_q <= ctrl_i.symbol;
    end
  end

endmodule

### hw/rtl/wildcard_glob_matcher_unit.sv
// Glob matcher: the result is registered and valid in the cycle after the input transfer.
// Throughput one item per cycle while each result is taken; the star recurrence ripples through the
// row of column cells within that cycle, like a carry chain.
// A result held by a stalled receiver blocks the input until it is taken.
// Reset empties the pattern and sets the match row to bit zero only;
// the pattern byte store is not cleared.
module wildcard_glob_matcher_unit import wgm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic            row0_q, row0_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_data_q, out_data_d;
  logic            take;
  logic            room;
  kind_e           kind;
  cell_ctrl_t      ctrl;
  chain_t          link [MAX_PATTERN + 1];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign kind       = kind_e'(in_data_i.kind);
  assign room       = pos_q < LenW'(MAX_PATTERN);

  // pattern length, load position and row zero match bit
  always_comb begin
    len_d  = len_q;
    pos_d  = pos_q;
    row0_d = row0_q;
    if (take) begin
      unique case (kind)
        KIND_LOAD: begin
          if (room) begin
            pos_d = pos_q + LenW'(1);
            len_d = pos_q + LenW'(1);
          end
          if (in_data_i.last) begin
            pos_d = '0;
          end
          row0_d = 1'b1;
        end
        KIND_TEXT: begin
          row0_d = in_data_i.last;
        end
        KIND_CLEAR: begin
          len_d  = '0;
          pos_d  = '0;
          row0_d = 1'b1;
        end
        default: begin
          row0_d = row0_q;
        end
      endcase
    end
  end

  // control broadcast to the cells
  always_comb begin
    ctrl.take     = take;
    ctrl.kind     = kind;
    ctrl.symbol   = in_data_i.symbol;
    ctrl.last     = in_data_i.last;
    ctrl.room     = room;
    ctrl.load_pos = pos_q;
    ctrl.len_next = len_d;
  end

  // column zero sits at the head of the chain
  assign link[0] = '{old: row0_q, adv: 1'b0, emp: 1'b1};

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    wgm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (LenW'(k)),
      .ctrl_i (ctrl),
      .left_i (link[k]),
      .right_o(link[k + 1])
    );
  end

  // result for this transfer
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      out_valid_d         = 1'b1;
      out_data_d.overflow = (kind == KIND_LOAD) && !room;
      unique case (kind)
        KIND_LOAD:  out_data_d.matched = link[len_d].emp;
        KIND_TEXT:  out_data_d.matched = link[len_q].adv;
        KIND_CLEAR: out_data_d.matched = 1'b1;
        default:    out_data_d.matched = link[len_q].old;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pos_q       <= '0;
      row0_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      pos_q       <= pos_d;
      row0_q      <= row0_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
